@@ rtl/dcp_pkg.sv @@
package dcp_pkg;

  localparam int POOL_DEPTH = 512;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int VAL_W   = 64;
  localparam int TAG_W   = 3;
  localparam int SLOT_W  = 9;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = TAG_W + VAL_W;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [TAG_W-1:0] TAG_INT   = 3'd0;
  localparam logic [TAG_W-1:0] TAG_FLOAT = 3'd1;
  localparam logic [TAG_W-1:0] TAG_CHAR  = 3'd2;
  localparam logic [TAG_W-1:0] TAG_BOOL  = 3'd3;
  localparam logic [TAG_W-1:0] TAG_REF   = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd4;

  function automatic logic is_nan(input logic [VAL_W-1:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // Equality of two constant values under the rule of their common tag.
  function automatic logic value_equal(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b,
                                       input logic [TAG_W-1:0] tag);
    logic eq;
    eq = 1'b0;
    case (tag)
      TAG_INT, TAG_REF: eq = (a == b);
      TAG_FLOAT: begin
        if (is_nan(a) || is_nan(b)) begin
          eq = 1'b0;
        end else if ((a[62:0] | b[62:0]) == 63'd0) begin
          eq = 1'b1;
        end else begin
          eq = (a == b);
        end
      end
      TAG_CHAR: eq = (a[31:0] == b[31:0]);
      TAG_BOOL: eq = (a[0] == b[0]);
      default:  eq = 1'b0;
    endcase
    return eq;
  endfunction

endpackage

@@ rtl/dedup_constant_pool.sv @@
// Channel | Handshake                  | Payload
// input   | in_valid / in_stall        | op, tag, value, index
// output  | out_valid / out_stall      | slot, status, read_value, read_tag
//
// A put reads the stored entries one per cycle through the entry RAM's single read port
// into one shared comparator; its result is valid once an entry matches or all stored
// entries have been compared. A get in range is read from the RAM and registered in
// S_GET; one out of range goes straight to S_DONE right after acceptance. One request is
// in flight: in_stall stays high until the result is taken and drops the cycle after. Reset
// clears the entry count and control state only, not the RAM; out_stall holds the result.
module dedup_constant_pool
  import dcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [TAG_W-1:0]  tag,
  input  logic [VAL_W-1:0]  value,
  input  logic [SLOT_W-1:0] index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot,
  output logic [STAT_W-1:0] status,
  output logic [VAL_W-1:0]  read_value,
  output logic [TAG_W-1:0]  read_tag
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_GET  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic [ADDR_W-1:0]  cmp_idx;
  logic               cmp_vld;
  logic [TAG_W-1:0]   item_tag;
  logic [VAL_W-1:0]   item_value;

  logic               accept;
  logic               in_range;
  logic               hit;
  logic               scan_end;
  logic               pool_full;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = (32'(index) < 32'(count));

  assign hit       = cmp_vld && (rd_data[ENTRY_W-1:VAL_W] == item_tag) &&
                     value_equal(rd_data[VAL_W-1:0], item_value, item_tag);
  assign scan_end  = (ptr == count);
  assign pool_full = (32'(count) == POOL_DEPTH);

  // Reads come from the get index at acceptance, else from the scan pointer.
  assign rd_addr = (state == S_IDLE) ? ADDR_W'(index) : ptr[ADDR_W-1:0];
  assign rd_en   = (accept && op == OP_GET && in_range) ||
                   (state == S_SCAN && !hit && !scan_end);
  assign wr_en   = (state == S_SCAN) && !hit && scan_end && !pool_full;

  dcp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({item_tag, item_value}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_tag   <= tag;
            item_value <= value;
            ptr        <= '0;
            cmp_vld    <= 1'b0;
            if (op == OP_PUT) begin
              state <= S_SCAN;
            end else if (in_range) begin
              state <= S_GET;
            end else begin
              slot       <= '0;
              status     <= ST_RANGE;
              read_value <= '0;
              read_tag   <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          read_value <= '0;
          read_tag   <= '0;
          if (hit) begin
            slot   <= SLOT_W'(cmp_idx);
            status <= ST_FOUND;
            state  <= S_DONE;
          end else if (scan_end) begin
            // No match among stored entries: append unless the pool is full.
            if (pool_full) begin
              slot   <= '0;
              status <= ST_FULL;
            end else begin
              slot   <= SLOT_W'(count);
              status <= ST_INSERTED;
              count  <= count + CNT_W'(1);
            end
            state <= S_DONE;
          end else begin
            cmp_idx <= ptr[ADDR_W-1:0];
            cmp_vld <= 1'b1;
            ptr     <= ptr + CNT_W'(1);
          end
        end
        S_GET: begin
          slot       <= '0;
          status     <= ST_READ_OK;
          read_value <= rd_data[VAL_W-1:0];
          read_tag   <= rd_data[ENTRY_W-1:VAL_W];
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= POOL_DEPTH)
    else $error("entry count above pool depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == ST_INSERTED |-> 32'(count) == 32'($past(count)) + 1)
    else $error("insert did not grow the table by one");

  a_found_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FOUND |-> 32'(slot) < 32'(count))
    else $error("found slot beyond stored entries");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == ST_FULL |-> $stable(count))
    else $error("table changed on pool full");

endmodule

@@ rtl/dcp_ram.sv @@
module dcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ dv/dedup_constant_pool_tb.sv @@
module dedup_constant_pool_tb;
  import dcp_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_GROW    = 900;
  localparam int RANDOM_FULL    = 220;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [TAG_W-1:0]  read_tag;
  } lookup_result_t;

  class intern_scoreboard;
    logic [VAL_W-1:0] vals[POOL_DEPTH];
    logic [TAG_W-1:0] tags[POOL_DEPTH];
    int unsigned count;
    lookup_result_t expected_results[$];
    int errors;
    int seen[8];

    function bit same_constant(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                               logic [TAG_W-1:0] t);
      bit a_nan;
      bit b_nan;
      a_nan = (&a[62:52]) && (|a[51:0]);
      b_nan = (&b[62:52]) && (|b[51:0]);
      if (t == TAG_INT || t == TAG_REF) return a == b;
      if (t == TAG_CHAR) return a[31:0] == b[31:0];
      if (t == TAG_BOOL) return a[0] == b[0];
      if (t != TAG_FLOAT || a_nan || b_nan) return 1'b0;
      // signed zeros compare equal
      return (a == b) || ({a[62:0], b[62:0]} == '0);
    endfunction

    function void note_request(logic o, logic [TAG_W-1:0] t, logic [VAL_W-1:0] v,
                               logic [SLOT_W-1:0] ix);
      lookup_result_t r;
      int unsigned i;
      r = '0;
      if (o == OP_GET) begin
        if (ix < count) begin
          r.status     = ST_READ_OK;
          r.read_value = vals[ix];
          r.read_tag   = tags[ix];
        end else begin
          r.status = ST_RANGE;
        end
      end else begin
        for (i = 0; i < count; i++) begin
          if (tags[i] == t && same_constant(vals[i], v, t)) break;
        end
        if (i < count) begin
          r.status = ST_FOUND;
          r.slot   = i[SLOT_W-1:0];
        end else if (count < POOL_DEPTH) begin
          vals[count] = v;
          tags[count] = t;
          r.status    = ST_INSERTED;
          r.slot      = count[SLOT_W-1:0];
          count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual slot %0d status %0d value %h tag %0d",
                 $time, got.slot, got.status, got.read_value, got.read_tag);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      seen[want.status]++;
      if (got.slot !== want.slot) begin
        $display("%0t: slot mismatch: expected %0d, actual %0d", $time, want.slot, got.slot);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.read_tag !== want.read_tag) begin
        $display("%0t: read_tag mismatch: expected %0d, actual %0d",
                 $time, want.read_tag, got.read_tag);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [TAG_W-1:0]  tag;
  logic [VAL_W-1:0]  value;
  logic [SLOT_W-1:0] index;
  logic              out_valid;
  logic              out_stall;
  logic [SLOT_W-1:0] slot;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_value;
  logic [TAG_W-1:0]  read_tag;

  intern_scoreboard sb;
  bit quiet;
  bit hold_request;
  int n_requests;
  int idle_cycles;

  dedup_constant_pool u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .tag        (tag),
    .value      (value),
    .index      (index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot       (slot),
    .status     (status),
    .read_value (read_value),
    .read_tag   (read_tag)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(lookup_result_t'{slot, status, read_value, read_tag});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("dedup_constant_pool_tb failed");
      $finish;
    end
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(logic o, logic [TAG_W-1:0] t, logic [VAL_W-1:0] v,
                              logic [SLOT_W-1:0] ix);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    tag      <= t;
    value    <= v;
    index    <= ix;
    // hold the request until the block takes it
    do @(posedge clk); while (in_stall);
    sb.note_request(o, t, v, ix);
    n_requests++;
  endtask

  task automatic put_const(logic [TAG_W-1:0] t, logic [VAL_W-1:0] v);
    send_request(OP_PUT, t, v, SLOT_W'($urandom_range(0, POOL_DEPTH - 1)));
  endtask

  task automatic get_entry(logic [SLOT_W-1:0] ix);
    send_request(OP_GET, TAG_W'($urandom_range(0, 7)), {$urandom, $urandom}, ix);
  endtask

  function automatic logic [TAG_W-1:0] rand_tag();
    int r;
    r = $urandom_range(0, 11);
    return (r < 10) ? TAG_W'(r % 5) : TAG_W'($urandom_range(5, 7));
  endfunction

  function automatic logic [VAL_W-1:0] rand_constant(logic [TAG_W-1:0] t);
    logic [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = v & 64'hFF;
      1: v = '1;
      2: if (t == TAG_FLOAT) v = {v[63], 63'd0};
      3: if (t == TAG_FLOAT) v = {v[63], 11'h7FF, v[51:1], 1'b1};
      4: if (t == TAG_FLOAT) v = {v[63], 11'h7FF, 52'd0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_item(int new_pct);
    int r;
    int unsigned i;
    logic [TAG_W-1:0] t;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0: i = $urandom_range(0, POOL_DEPTH - 1);
        1: i = (sb.count < POOL_DEPTH) ? $urandom_range(sb.count, POOL_DEPTH - 1)
                                       : $urandom_range(0, POOL_DEPTH - 1);
        default: i = (sb.count > 0) ? $urandom_range(0, sb.count - 1) : 0;
      endcase
      get_entry(i[SLOT_W-1:0]);
    end else if (r < 20 + new_pct || sb.count == 0) begin
      t = rand_tag();
      put_const(t, rand_constant(t));
    end else begin
      // revisit a stored constant, disturbing only bits its tag ignores; now and then the tag is changed too
      i = $urandom_range(0, sb.count - 1);
      t = sb.tags[i];
      v = sb.vals[i];
      w = {$urandom, $urandom};
      case (t)
        TAG_CHAR:  v[63:32] = w[63:32];
        TAG_BOOL:  v = {w[63:1], v[0]};
        TAG_FLOAT: if (v[62:0] == '0) v[63] = w[0];
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) t = t ^ 3'd4;
      put_const(t, v);
    end
  endtask

  initial begin
    sb = new();
    quiet        = 1'b0;
    hold_request = 1'b0;
    n_requests   = 0;
    idle_cycles  = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= OP_PUT;
    tag      <= '0;
    value    <= '0;
    index    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    get_entry(9'd0);
    get_entry(9'd511);
    put_const(TAG_INT, 64'd0);
    put_const(TAG_INT, '1);
    put_const(TAG_INT, 64'd0);
    put_const(TAG_REF, 64'd0);
    put_const(TAG_FLOAT, 64'h0000_0000_0000_0000);
    put_const(TAG_FLOAT, 64'h8000_0000_0000_0000);
    put_const(TAG_FLOAT, 64'h7FF8_0000_0000_0001);
    put_const(TAG_FLOAT, 64'h7FF8_0000_0000_0001);
    put_const(TAG_FLOAT, 64'h7FF0_0000_0000_0000);
    put_const(TAG_FLOAT, 64'h7FF0_0000_0000_0000);
    put_const(TAG_FLOAT, 64'hFFF0_0000_0000_0000);
    put_const(TAG_CHAR, 64'hDEAD_BEEF_0000_0041);
    put_const(TAG_CHAR, 64'h0000_0000_0000_0041);
    put_const(TAG_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
    put_const(TAG_BOOL, 64'h0000_0000_0000_0002);
    put_const(TAG_BOOL, 64'h0000_0000_0000_0001);
    put_const(3'd5, 64'd7);
    put_const(3'd5, 64'd7);
    put_const(3'd7, '1);
    put_const(3'd6, 64'd0);
    get_entry(9'd8);
    get_entry(9'd14);
    get_entry(9'd15);

    for (int k = 0; k < RANDOM_GROW; k++) begin
      if (k == 200) hold_request = 1'b1;
      if (k == 400) begin
        // drain the pipe before going on
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
      random_item(60);
    end

    while (sb.count < POOL_DEPTH) put_const(TAG_INT, {$urandom, $urandom});
    put_const(TAG_REF, {$urandom, $urandom});
    put_const(TAG_INT, 64'd0);
    get_entry(9'd511);
    get_entry(9'd0);

    for (int k = 0; k < RANDOM_FULL; k++) begin
      if (k == 100) quiet = 1'b1;
      random_item(40);
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (POOL_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d hits, %0d pool full, %0d reads, %0d out of range",
             n_requests, sb.seen[ST_INSERTED], sb.seen[ST_FOUND], sb.seen[ST_FULL],
             sb.seen[ST_READ_OK], sb.seen[ST_RANGE]);
    $display("table grew to %0d of %0d entries, %0d mismatches", sb.count, POOL_DEPTH,
             sb.errors);
    if (sb.errors == 0) begin
      $display("dedup_constant_pool_tb passed");
    end else begin
      $display("dedup_constant_pool_tb failed");
    end
    $finish;
  end

endmodule

@@ dedup_constant_pool.f @@
rtl/dcp_pkg.sv
rtl/dcp_ram.sv
rtl/dedup_constant_pool.sv
dv/dedup_constant_pool_tb.sv
